### rtl/shr_pkg.sv
// Package for the string history ring: sizes, status codes, sequencer states, ring index math.
package shr_pkg;

  localparam int HIST_LEN = 64;
  localparam int IW       = $clog2(HIST_LEN);

  typedef logic [IW-1:0] idx_t;

  localparam idx_t LAST_IDX = IW'(HIST_LEN - 1);

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_RECALL = 1'b1;

  localparam logic [2:0] ST_STORED   = 3'd0;
  localparam logic [2:0] ST_OVERFLOW = 3'd1;
  localparam logic [2:0] ST_DISCARD  = 3'd2;
  localparam logic [2:0] ST_BYTE     = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPEND,
    S_FRD,
    S_FCHK,
    S_BRD,
    S_BCHK
  } shr_state_t;

  function automatic idx_t idx_next(idx_t i);
    return (i == LAST_IDX) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t idx_prev(idx_t i);
    return (i == '0) ? LAST_IDX : idx_t'(i - 1'b1);
  endfunction

endpackage

### rtl/string_history_ring_core.sv
// Command-line history kept as NUL-terminated strings in a byte ring.
// Append: the result is registered from S_APPEND once the output is free; a new word is
//   taken only back in S_IDLE. Recall: each ring position visited takes a read state and
//   a check state (single read port, registered read data), both for the backward search
//   and the forward byte walk, plus any time the output is held off.
// Reset (rst_n low, synchronous): ring reads as byte 0 = 0, rest 0xFF via per-entry valid
//   flops; tail and cursor 0, no entry open, no discard, output empty.
module string_history_ring_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [13:8] entry_age, [15:14] zero
  input  logic [0:0]  in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte_res, [13:8] start_offset, [15:14] zero
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic        out_tlast
);
  import shr_pkg::*;

  shr_state_t state_r, state_nxt;

  idx_t       tail_r, tail_nxt;
  idx_t       cursor_r, cursor_nxt;
  idx_t       idx_r, idx_nxt;
  idx_t       start_r, start_nxt;
  logic       open_r, open_nxt;
  logic       disc_r, disc_nxt;
  logic       pend_vld_r, pend_vld_nxt;
  logic [7:0] pend_r, pend_nxt;
  logic [5:0] age_r, age_nxt;
  logic [7:0] byte_r, byte_nxt;

  logic [7:0]          mem [HIST_LEN];
  logic [HIST_LEN-1:0] valid_r;
  logic [7:0]          rdata_r;
  logic                rd_vld_r;

  logic       mem_we;
  idx_t       waddr;
  logic       ring_clr;

  logic       out_valid_r;
  logic [2:0] out_status_r, out_status_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic [5:0] out_start_r, out_start_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_load;
  logic       out_free;

  logic [7:0] rd_byte;
  idx_t       stop;
  idx_t       guard;
  idx_t       cur;
  logic       cont;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  // unwritten entries read as their reset value
  assign rd_byte = rd_vld_r ? rdata_r : ((idx_r == '0) ? 8'h00 : 8'hFF);
  assign stop    = idx_next(tail_r);
  assign guard   = idx_prev(start_r);
  assign cur     = open_r ? cursor_r : idx_next(tail_r);
  assign cont    = (rd_byte != 8'h00) && (idx_r != guard);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = (in_tuser[0] == OP_RECALL) ? S_FRD : S_APPEND;
        end
      end
      S_APPEND: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_FRD: state_nxt = S_FCHK;
      S_FCHK: begin
        if (idx_r == stop) begin
          if (out_free) state_nxt = S_IDLE;
        end else if (rd_byte == 8'h00 && age_r == '0) begin
          state_nxt = S_BRD;
        end else begin
          state_nxt = S_FRD;
        end
      end
      S_BRD: state_nxt = S_BCHK;
      S_BCHK: begin
        if (cont) begin
          if (!pend_vld_r || out_free) state_nxt = S_BRD;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    tail_nxt       = tail_r;
    cursor_nxt     = cursor_r;
    idx_nxt        = idx_r;
    start_nxt      = start_r;
    open_nxt       = open_r;
    disc_nxt       = disc_r;
    pend_vld_nxt   = pend_vld_r;
    pend_nxt       = pend_r;
    age_nxt        = age_r;
    byte_nxt       = byte_r;
    mem_we         = 1'b0;
    waddr          = cur;
    ring_clr       = 1'b0;
    out_load       = 1'b0;
    out_status_nxt = ST_STORED;
    out_byte_nxt   = 8'h00;
    out_start_nxt  = '0;
    out_last_nxt   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          byte_nxt     = in_tdata[7:0];
          age_nxt      = in_tdata[13:8];
          idx_nxt      = idx_prev(tail_r);
          pend_vld_nxt = 1'b0;
        end
      end
      S_APPEND: begin
        if (out_free) begin
          out_load = 1'b1;
          if (disc_r) begin
            out_status_nxt = ST_DISCARD;
            if (byte_r == 8'h00) disc_nxt = 1'b0;
          end else if (cur == idx_prev(tail_r)) begin
            out_status_nxt = ST_OVERFLOW;
            ring_clr       = 1'b1;
            tail_nxt       = '0;
            cursor_nxt     = '0;
            open_nxt       = 1'b0;
            disc_nxt       = (byte_r != 8'h00);
          end else begin
            out_status_nxt = ST_STORED;
            mem_we         = 1'b1;
            if (byte_r == 8'h00) begin
              tail_nxt   = cur;
              cursor_nxt = cur;
              open_nxt   = 1'b0;
            end else begin
              cursor_nxt = idx_next(cur);
              open_nxt   = 1'b1;
            end
          end
        end
      end
      S_FCHK: begin
        if (idx_r == stop) begin
          if (out_free) begin
            out_load       = 1'b1;
            out_status_nxt = ST_NOTFOUND;
          end
        end else if (rd_byte == 8'h00) begin
          if (age_r == '0) begin
            start_nxt = idx_next(idx_r);
            idx_nxt   = idx_next(idx_r);
          end else begin
            age_nxt = age_r - 6'd1;
            idx_nxt = idx_prev(idx_r);
          end
        end else begin
          idx_nxt = idx_prev(idx_r);
        end
      end
      S_BCHK: begin
        out_start_nxt = 6'(start_r);
        if (cont) begin
          if (!pend_vld_r || out_free) begin
            out_load       = pend_vld_r;
            out_status_nxt = ST_BYTE;
            out_byte_nxt   = pend_r;
            out_last_nxt   = 1'b0;
            pend_nxt       = rd_byte;
            pend_vld_nxt   = 1'b1;
            idx_nxt        = idx_next(idx_r);
          end
        end else if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = pend_vld_r ? ST_BYTE : ST_EMPTY;
          out_byte_nxt   = pend_vld_r ? pend_r : 8'h00;
          pend_vld_nxt   = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      tail_r     <= '0;
      cursor_r   <= '0;
      open_r     <= 1'b0;
      disc_r     <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      tail_r     <= tail_nxt;
      cursor_r   <= cursor_nxt;
      open_r     <= open_nxt;
      disc_r     <= disc_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    start_r <= start_nxt;
    pend_r  <= pend_nxt;
    age_r   <= age_nxt;
    byte_r  <= byte_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ring_clr) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= byte_r;
    rdata_r  <= mem[idx_r];
    rd_vld_r <= valid_r[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_load || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_byte_r   <= out_byte_nxt;
      out_start_r  <= out_start_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_start_r, out_byte_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_disc_closed: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> !open_r)
    else $error("discarding while an entry is open");

  a_open_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (cursor_r != tail_r))
    else $error("write cursor caught up with tail");

  a_ovf_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_status_nxt == ST_OVERFLOW) |=> (tail_r == '0 && !open_r))
    else $error("overflow did not reset the ring");

  a_pend_walk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_vld_r |-> (state_r == S_BRD || state_r == S_BCHK))
    else $error("pending recall byte outside the byte walk");
`endif

endmodule

### tb/tb_string_history_ring_core.sv
// Self-checking testbench for string_history_ring_core: directed and random append/recall vs a predictor.
`timescale 1ns / 1ps

module tb_string_history_ring_core;
  import shr_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 280;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] data;
    idx_t       start;
    logic       last;
  } ring_word_t;

  class ring_history_check;
    logic [7:0] ring_mem [HIST_LEN];
    int         tail_pos;
    int         cur_pos;
    bit         entry_open;
    bit         discarding;
    ring_word_t pending_results[$];
    int         errors;

    function new();
      clear_history();
      discarding = 0;
      errors = 0;
    endfunction

    function int fwd(int i);
      return (i + 1) % HIST_LEN;
    endfunction

    function int back(int i);
      return (i + HIST_LEN - 1) % HIST_LEN;
    endfunction

    function void clear_history();
      for (int i = 0; i < HIST_LEN; i++) ring_mem[i] = 8'hFF;
      ring_mem[0] = 8'h00;
      tail_pos = 0;
      cur_pos = 0;
      entry_open = 0;
    endfunction

    function void push_word(logic [2:0] st, logic [7:0] d, int start, logic lst);
      ring_word_t w;
      w.status = st;
      w.data = d;
      w.start = idx_t'(start);
      w.last = lst;
      pending_results.push_back(w);
    endfunction

    function void apply_append(logic [7:0] b);
      if (discarding) begin
        if (b == 8'h00) discarding = 0;
        push_word(ST_DISCARD, 8'h00, 0, 1'b1);
        return;
      end
      if (!entry_open) begin
        cur_pos = fwd(tail_pos);
        entry_open = 1;
      end
      if (cur_pos == back(tail_pos)) begin
        clear_history();
        discarding = (b != 8'h00);
        push_word(ST_OVERFLOW, 8'h00, 0, 1'b1);
        return;
      end
      ring_mem[cur_pos] = b;
      if (b == 8'h00) begin
        tail_pos = cur_pos;
        entry_open = 0;
      end else begin
        cur_pos = fwd(cur_pos);
      end
      push_word(ST_STORED, 8'h00, 0, 1'b1);
    endfunction

    function void apply_recall(logic [5:0] age);
      int stop_pos;
      int i;
      int skip;
      int start;
      int guard;
      int j;
      int k;
      bit found;
      ring_word_t prev;
      stop_pos = fwd(tail_pos);
      i = back(tail_pos);
      skip = age;
      start = 0;
      found = 0;
      while (i != stop_pos && !found) begin
        if (ring_mem[i] == 8'h00) begin
          if (skip == 0) begin
            start = fwd(i);
            found = 1;
          end else begin
            skip--;
          end
        end
        if (!found) i = back(i);
      end
      if (!found) begin
        push_word(ST_NOTFOUND, 8'h00, 0, 1'b1);
        return;
      end
      guard = back(start);
      j = start;
      k = 0;
      while (ring_mem[j] != 8'h00 && j != guard && k < HIST_LEN - 1) begin
        if (k > 0) pending_results.push_back(prev);
        prev.status = ST_BYTE;
        prev.data = ring_mem[j];
        prev.start = idx_t'(start);
        prev.last = 1'b0;
        k++;
        j = fwd(j);
      end
      if (k == 0) begin
        push_word(ST_EMPTY, 8'h00, start, 1'b1);
      end else begin
        prev.last = 1'b1;
        pending_results.push_back(prev);
      end
    endfunction

    function void note_word(logic op, logic [7:0] b, logic [5:0] age);
      if (op == OP_APPEND) apply_append(b);
      else apply_recall(age);
    endfunction

    function void check_word(logic [2:0] st, logic [7:0] d, idx_t start, logic lst,
                             logic [1:0] pad);
      ring_word_t w;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: status %0d byte %02h start %0d last %0d",
                   st, d, start, lst);
        return;
      end
      w = pending_results.pop_front();
      if (w.status !== st || w.data !== d || w.start !== start || w.last !== lst ||
          pad !== 2'b00) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp status %0d byte %02h start %0d last %0d | got status %0d byte %02h start %0d last %0d pad %b",
                   w.status, w.data, w.start, w.last, st, d, start, lst, pad);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] data_byte, [13:8] entry_age, [15:14] zero
  logic [0:0]  in_tuser;   // [0] operation
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [7:0] data_byte_res, [13:8] start_offset, [15:14] zero
  logic [2:0]  out_tuser;  // [2:0] status
  logic        out_tlast;

  ring_history_check sb;
  int items_sent;
  int quiet_cycles;
  bit idle_on;
  bit hold_req;

  string_history_ring_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_word(in_tuser[0], in_tdata[7:0], in_tdata[13:8]);
      if (out_tvalid && out_tready)
        sb.check_word(out_tuser, out_tdata[7:0], idx_t'(out_tdata[13:8]), out_tlast,
                      out_tdata[15:14]);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // sink side: random back-pressure bursts, one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_req = 0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 5)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(logic op, logic [7:0] b, logic [5:0] age);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {2'b00, age, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic type_entry(int len);
    for (int n = 0; n < len; n++) begin
      send_word(OP_APPEND, 8'($urandom_range(1, 255)), 6'($urandom));
      if ($urandom_range(0, 15) == 0)
        send_word(OP_RECALL, 8'($urandom), 6'($urandom_range(0, 3)));
    end
    send_word(OP_APPEND, 8'h00, 6'($urandom));
  endtask

  initial begin
    int random_end;
    int entry_cnt;
    int pick;
    int len;
    bit pressure_done;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    items_sent = 0;
    quiet_cycles = 0;
    idle_on = 1;
    hold_req = 0;
    pressure_done = 0;
    entry_cnt = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty ring, empty entry, byte extremes, recall while typing
    send_word(OP_RECALL, 8'hFF, 6'd0);
    send_word(OP_APPEND, 8'h00, 6'd63);
    send_word(OP_RECALL, 8'h00, 6'd0);
    send_word(OP_APPEND, 8'hFF, 6'd0);
    send_word(OP_APPEND, 8'h01, 6'd0);
    send_word(OP_APPEND, 8'h80, 6'd0);
    send_word(OP_APPEND, 8'h7F, 6'd0);
    send_word(OP_APPEND, 8'h00, 6'd0);
    send_word(OP_RECALL, 8'h00, 6'd0);
    send_word(OP_RECALL, 8'h00, 6'd1);
    send_word(OP_RECALL, 8'h00, 6'd2);
    send_word(OP_RECALL, 8'h00, 6'd63);
    send_word(OP_APPEND, 8'hAA, 6'd0);
    send_word(OP_APPEND, 8'h55, 6'd0);
    send_word(OP_RECALL, 8'h00, 6'd0);
    send_word(OP_RECALL, 8'h00, 6'd1);
    send_word(OP_APPEND, 8'h00, 6'd0);
    send_word(OP_RECALL, 8'hFF, 6'd0);
    send_word(OP_RECALL, 8'hFF, 6'd42);

    random_end = items_sent + RANDOM_ITEMS;
    while (items_sent < random_end) begin
      if (items_sent >= random_end - 40) idle_on = 0;
      if (!pressure_done && items_sent >= random_end - RANDOM_ITEMS + 100) begin
        hold_req = 1;
        pressure_done = 1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // long entries are sized around the ring limit: overflow on a byte, on the NUL, or not at all
        if (entry_cnt == 1 || $urandom_range(0, 9) == 0) len = $urandom_range(60, 66);
        else len = $urandom_range(0, 8);
        type_entry(len);
        entry_cnt++;
      end else if (pick < 85) begin
        if ($urandom_range(0, 9) < 7) send_word(OP_RECALL, 8'($urandom), 6'($urandom_range(0, 4)));
        else send_word(OP_RECALL, 8'($urandom), 6'($urandom));
      end else begin
        send_word(1'($urandom), 8'($urandom), 6'($urandom));
      end
    end
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
